FILE: rtl/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types and constants for the random color fader.
// ----------------------------------------------------------------------------
package rfc_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int NUM_CHANNELS = 3;
  localparam int RAND_BITS    = 16;
  localparam int DELAY_BITS   = 24;
  localparam int BOUNDS_BITS  = 2 * CHANNEL_BITS;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = DELAY_BITS;
  localparam int DIV_BITS     = RAND_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic signed [CHANNEL_BITS:0] step_t;
  typedef logic [BOUNDS_BITS-1:0] bounds_t;
  typedef logic [DELAY_BITS-1:0] delay_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RED_BOUNDS   = 3'd0,
    REG_GREEN_BOUNDS = 3'd1,
    REG_BLUE_BOUNDS  = 3'd2,
    REG_STEP_DELAY   = 3'd3,
    REG_PAUSE_DELAY  = 3'd4,
    REG_STEP_COUNT   = 3'd5
  } reg_idx_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_EMIT,
    ST_MOD,
    ST_PICK,
    ST_STEP,
    ST_DIV
  } state_t;

  // Per-lane command bundle from the sequencer.
  typedef struct packed {
    logic load_set;
    logic load_cand;
    logic mod_start;
    logic step_start;
    logic advance;
    logic last;
  } lane_cmd_t;

endpackage

FILE: rtl/rfc_div.sv
// ----------------------------------------------------------------------------
// rfc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rfc_div import rfc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIV_BITS-1:0] dividend,
  input  chan_t               divisor,
  output logic                done,
  output logic [DIV_BITS-1:0] quot,
  output chan_t               rem
);

  logic                    busy;
  logic [DIV_CNT_BITS-1:0] cnt;
  chan_t                   dsr;
  logic [CHANNEL_BITS:0]   trial;
  logic [CHANNEL_BITS:0]   trial_sub;
  logic                    ge;

  assign trial     = {rem, quot[DIV_BITS-1]};
  assign ge        = trial >= {1'b0, dsr};
  assign trial_sub = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_BITS'(DIV_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      quot <= {quot[DIV_BITS-2:0], ge};
      rem  <= ge ? trial_sub[CHANNEL_BITS-1:0] : trial[CHANNEL_BITS-1:0];
    end
  end

endmodule

FILE: rtl/rfc_lane.sv
// ----------------------------------------------------------------------------
// rfc_lane
// One color channel: current/target/step state, random draw with snapping,
// per-step divide and the fade advance.
// ----------------------------------------------------------------------------
module rfc_lane import rfc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  lane_cmd_t            cmd,
  input  chan_t                set_val,
  input  logic [RAND_BITS-1:0] rand_word,
  input  bounds_t              bounds,
  input  chan_t                n_eff,
  output logic                 done,
  output chan_t                current,
  output chan_t                target,
  output chan_t                cand,
  output chan_t                adv
);

  localparam int NUM_EDGES = 5;
  localparam chan_t EDGE_LEVELS [NUM_EDGES] = '{
    chan_t'(0), chan_t'(63), chan_t'(127), chan_t'(191), chan_t'(255)
  };

  function automatic chan_t chan_dist(chan_t a, chan_t b);
    return (a > b) ? chan_t'(a - b) : chan_t'(b - a);
  endfunction

  // Nearest of lo, hi, then the edge levels; earlier candidates win ties.
  function automatic chan_t snap_level(chan_t pick, chan_t lo, chan_t hi);
    chan_t best;
    chan_t bestd;
    chan_t d;
    best  = lo;
    bestd = chan_dist(pick, lo);
    d     = chan_dist(pick, hi);
    if (d < bestd) begin
      best  = hi;
      bestd = d;
    end
    for (int i = 0; i < NUM_EDGES; i++) begin
      d = chan_dist(pick, EDGE_LEVELS[i]);
      if (d < bestd) begin
        best  = EDGE_LEVELS[i];
        bestd = d;
      end
    end
    return best;
  endfunction

  step_t                 step;
  logic                  mode_mod;
  logic                  neg;
  chan_t                 lo;
  chan_t                 hi;
  chan_t                 span;
  chan_t                 pick;
  logic [CHANNEL_BITS:0] diff;
  chan_t                 mag;
  logic                  div_start;
  logic [DIV_BITS-1:0]   div_dividend;
  chan_t                 div_divisor;
  logic [DIV_BITS-1:0]   quot;
  chan_t                 rem;
  logic signed [CHANNEL_BITS+1:0] sum;

  assign lo   = bounds[CHANNEL_BITS-1:0];
  assign hi   = bounds[BOUNDS_BITS-1:CHANNEL_BITS];
  assign span = chan_t'(hi - lo);
  assign pick = (hi > lo) ? chan_t'(lo + rem) : lo;

  assign diff = {1'b0, target} - {1'b0, current};
  assign mag  = diff[CHANNEL_BITS] ? chan_t'(-diff) : diff[CHANNEL_BITS-1:0];

  assign div_start    = cmd.mod_start | cmd.step_start;
  assign div_dividend = cmd.mod_start ? rand_word : DIV_BITS'(mag);
  assign div_divisor  = cmd.mod_start ? span : n_eff;

  rfc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (done),
    .quot     (quot),
    .rem      (rem)
  );

  // Fade advance with clamp to the channel range; the last step lands on the target.
  assign sum = $signed({2'b00, current}) + $signed({step[CHANNEL_BITS], step});
  always_comb begin
    if (cmd.last) begin
      adv = target;
    end else if (sum < 0) begin
      adv = '0;
    end else if (sum > $signed({2'b00, {CHANNEL_BITS{1'b1}}})) begin
      adv = '1;
    end else begin
      adv = sum[CHANNEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current  <= '0;
      target   <= '0;
      step     <= '0;
      mode_mod <= 1'b0;
    end else begin
      if (cmd.mod_start) begin
        mode_mod <= 1'b1;
      end else if (cmd.step_start) begin
        mode_mod <= 1'b0;
      end
      if (cmd.load_set) begin
        target <= set_val;
      end else if (cmd.load_cand) begin
        target <= cand;
      end
      if (cmd.advance) begin
        current <= adv;
      end
      if (done && !mode_mod) begin
        step <= neg ? -step_t'({1'b0, quot[CHANNEL_BITS-1:0]})
                    : step_t'({1'b0, quot[CHANNEL_BITS-1:0]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_start) begin
      neg <= diff[CHANNEL_BITS];
    end
    if (done && mode_mod) begin
      cand <= snap_level(pick, lo, hi);
    end
  end

endmodule

FILE: rtl/random_color_fader.sv
// ----------------------------------------------------------------------------
// random_color_fader
// RGB fader: steps a color toward a target on millisecond ticks and draws
// new random targets once a fade is done and the pause has elapsed.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item: a millisecond tick
//   (opcode 0, with three random words) or a set-color command (opcode 1).
//   Output channel (out_valid/out_ready) carries the newly shown color for
//   each tick that makes a fade step; other items give no output.
//   Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// Processing, one item at a time:
//   tick with no action      TICK, then back to IDLE
//   tick with a fade step    TICK, then EMIT, which registers the color out
//   set color                STEP, then one divider pass in DIV
//   tick with a random draw  TICK, MOD, PICK, STEP, DIV (two passes of each
//                            lane's shift-subtract divider: modulo, then step),
//                            ending at PICK when a gray or unchanged draw is dropped
//   The three channels run in their own lanes in lockstep.
// Reset clears color, target, steps, counters and loads default registers.
// A stalled receiver holds the output register; items that do not step the
// color keep flowing, a stepping tick waits until the output is free.
// ----------------------------------------------------------------------------
module random_color_fader import rfc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     opcode,
  input  chan_t                    set_red,
  input  chan_t                    set_green,
  input  chan_t                    set_blue,
  input  logic [RAND_BITS-1:0]     rand_red,
  input  logic [RAND_BITS-1:0]     rand_green,
  input  logic [RAND_BITS-1:0]     rand_blue,
  output logic                     out_valid,
  input  logic                     out_ready,
  output chan_t                    out_red,
  output chan_t                    out_green,
  output chan_t                    out_blue,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  bounds_t red_bounds;
  bounds_t green_bounds;
  bounds_t blue_bounds;
  delay_t  step_delay;
  delay_t  pause_delay;
  chan_t   step_count;

  state_t  state;
  state_t  state_next;
  chan_t   step_index;
  delay_t  elapsed;

  logic [RAND_BITS-1:0] rand_q [NUM_CHANNELS];
  chan_t   set_val   [NUM_CHANNELS];
  bounds_t lane_bnd  [NUM_CHANNELS];
  logic    lane_done [NUM_CHANNELS];
  chan_t   lane_cur  [NUM_CHANNELS];
  chan_t   lane_tgt  [NUM_CHANNELS];
  chan_t   lane_cand [NUM_CHANNELS];
  chan_t   lane_adv  [NUM_CHANNELS];

  lane_cmd_t cmd;
  chan_t     n_eff;
  logic      fading;
  logic      last;
  logic      same;
  logic      unchanged;
  logic      gray;
  logic      elapsed_clr;
  logic      elapsed_inc;
  logic      emit_go;
  logic      idx_load;
  logic      in_acc;

  assign n_eff  = (step_count == '0) ? chan_t'(1) : step_count;
  assign fading = step_index < n_eff;
  assign last   = step_index == chan_t'(n_eff - 1'b1);
  assign in_ready = state == ST_IDLE;
  assign in_acc   = in_valid && in_ready;

  assign set_val[0]  = set_red;
  assign set_val[1]  = set_green;
  assign set_val[2]  = set_blue;
  assign lane_bnd[0] = red_bounds;
  assign lane_bnd[1] = green_bounds;
  assign lane_bnd[2] = blue_bounds;

  // Merge stage: compare what the lanes hold.
  assign same = (lane_tgt[0] == lane_cur[0]) && (lane_tgt[1] == lane_cur[1]) &&
                (lane_tgt[2] == lane_cur[2]);
  assign unchanged = (lane_cand[0] == lane_cur[0]) && (lane_cand[1] == lane_cur[1]) &&
                     (lane_cand[2] == lane_cur[2]);
  assign gray = (lane_cand[0] == lane_cand[1]) && (lane_cand[0] == lane_cand[2]);

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_lane
    rfc_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .set_val   (set_val[c]),
      .rand_word (rand_q[c]),
      .bounds    (lane_bnd[c]),
      .n_eff     (n_eff),
      .done      (lane_done[c]),
      .current   (lane_cur[c]),
      .target    (lane_tgt[c]),
      .cand      (lane_cand[c]),
      .adv       (lane_adv[c])
    );
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      red_bounds   <= bounds_t'(16'hFF00);
      green_bounds <= bounds_t'(16'hFF00);
      blue_bounds  <= bounds_t'(16'hFF00);
      step_delay   <= '0;
      pause_delay  <= '0;
      step_count   <= chan_t'(10);
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RED_BOUNDS:   red_bounds   <= cfg_data[BOUNDS_BITS-1:0];
        REG_GREEN_BOUNDS: green_bounds <= cfg_data[BOUNDS_BITS-1:0];
        REG_BLUE_BOUNDS:  blue_bounds  <= cfg_data[BOUNDS_BITS-1:0];
        REG_STEP_DELAY:   step_delay   <= cfg_data[DELAY_BITS-1:0];
        REG_PAUSE_DELAY:  pause_delay  <= cfg_data[DELAY_BITS-1:0];
        REG_STEP_COUNT:   step_count   <= cfg_data[CHANNEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.last    = last;
    elapsed_clr = 1'b0;
    elapsed_inc = 1'b0;
    emit_go     = 1'b0;
    idx_load    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (opcode_t'(opcode) == OP_SET) begin
            cmd.load_set = 1'b1;
            elapsed_clr  = 1'b1;
            state_next   = ST_STEP;
          end else begin
            elapsed_inc = 1'b1;
            state_next  = ST_TICK;
          end
        end
      end
      ST_TICK: begin
        if (fading) begin
          state_next = (elapsed >= step_delay) ? ST_EMIT : ST_IDLE;
        end else if (elapsed >= pause_delay) begin
          cmd.mod_start = 1'b1;
          state_next    = ST_MOD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          emit_go     = 1'b1;
          cmd.advance = 1'b1;
          elapsed_clr = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_MOD: begin
        if (lane_done[0]) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        // gray or unchanged draws are dropped and retried on the next tick
        if (unchanged || gray) begin
          state_next = ST_IDLE;
        end else begin
          cmd.load_cand = 1'b1;
          elapsed_clr   = 1'b1;
          state_next    = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step_start = 1'b1;
        idx_load       = 1'b1;
        state_next     = ST_DIV;
      end
      ST_DIV: begin
        if (lane_done[0]) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index <= '0;
      elapsed    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (emit_go) begin
        step_index <= step_index + 1'b1;
      end else if (idx_load) begin
        step_index <= same ? n_eff : '0;
      end
      if (elapsed_clr) begin
        elapsed <= '0;
      end else if (elapsed_inc && (elapsed != '1)) begin
        elapsed <= elapsed + 1'b1;
      end
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rand_q[0] <= rand_red;
      rand_q[1] <= rand_green;
      rand_q[2] <= rand_blue;
    end
    if (emit_go) begin
      out_red   <= lane_adv[0];
      out_green <= lane_adv[1];
      out_blue  <= lane_adv[2];
    end
  end

  // Lanes run in lockstep, so their dividers finish together.
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    (lane_done[0] == lane_done[1]) && (lane_done[1] == lane_done[2]))
    else $error("lane dividers out of step");

  // A fade step is only shown while a fade is in progress.
  a_emit_fading: assert property (@(posedge clk) disable iff (rst)
    emit_go |-> fading)
    else $error("fade step outside a fade");

  // A shown step lands in the output register on the next edge.
  a_emit_out: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> out_valid && (out_red == $past(lane_adv[0])))
    else $error("fade step not presented");

  // Draws only start once the fade is over.
  a_draw_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.mod_start |-> !fading)
    else $error("draw during fade");

endmodule
